@@ rtl/fcc_pkg.sv @@
package fcc_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int POINT_W     = 15;
  localparam int DEG16_W     = 11;
  localparam int PCT_W       = 7;
  localparam int TEMP_W      = 12;
  localparam int RPM_W       = 16;
  localparam int TIMER_W     = 16;
  localparam int ACC_W       = 18;
  localparam int QBITS       = 7;
  localparam int QIDX_W      = 3;

  // item commands
  localparam logic [1:0] CMD_TEMP    = 2'd0;
  localparam logic [1:0] CMD_RPM     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  // fan states
  localparam logic [1:0] ST_OFF   = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_ON    = 2'd2;
  localparam logic [1:0] ST_STALL = 2'd3;

  // register map
  localparam int                     CURVE_REGS        = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_STALL_RPM     = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_START_MS      = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_STALL_WAIT_MS = 8'd7;

  localparam logic [RPM_W-1:0]   STALL_RPM_RST     = 16'd140;
  localparam logic [TIMER_W-1:0] START_MS_RST      = 16'd1000;
  localparam logic [TIMER_W-1:0] STALL_WAIT_MS_RST = 16'd3000;

  localparam logic [PCT_W-1:0] FULL_DUTY    = 7'd100;
  localparam logic [PCT_W-1:0] MIN_SETPOINT = 7'd5;
  localparam logic [6:0]       MAX_DEG      = 7'd100;

  typedef struct packed {
    logic load_item;
    logic seg_find;
    logic mul_hi;
    logic mul_lo;
    logic div_step;
    logic fan_step;
  } fcc_cmd_t;

  typedef struct packed {
    logic is_temp;
    logic seg_hit;
    logic div_last;
  } fcc_status_t;

  function automatic logic [POINT_W-1:0] point_default(input int i);
    logic [POINT_W-1:0] v;
    case (i)
      0:       v = 15'd20;
      1:       v = 15'd5140;
      2:       v = 15'd9005;
      3:       v = 15'd11610;
      default: v = 15'd15460;
    endcase
    return v;
  endfunction

  // degrees part in sixteenths, clamped to 100 degrees
  function automatic logic [DEG16_W-1:0] pt_deg16(input logic [POINT_W-1:0] p);
    logic [6:0] d;
    d = p[14:8];
    if (d > MAX_DEG) d = MAX_DEG;
    return {d, 4'b0000};
  endfunction

  function automatic logic [PCT_W-1:0] pt_pct(input logic [POINT_W-1:0] p);
    logic [7:0] v;
    v = p[7:0];
    if (v > 8'd100) v = 8'd100;
    return v[PCT_W-1:0];
  endfunction

endpackage

@@ rtl/fcc_if.sv @@
interface fcc_item_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         cmd;
  logic signed [fcc_pkg::TEMP_W-1:0]  temperature;
  logic [fcc_pkg::RPM_W-1:0]          rpm;

  modport source (output valid, cmd, temperature, rpm, input ready);
  modport sink   (input valid, cmd, temperature, rpm, output ready);
endinterface

interface fcc_result_if;
  logic                       valid;
  logic                       ready;
  logic [fcc_pkg::PCT_W-1:0]  duty;
  logic                       duty_written;
  logic [1:0]                 fan_state;

  modport source (output valid, duty, duty_written, fan_state, input ready);
  modport sink   (input valid, duty, duty_written, fan_state, output ready);
endinterface

interface fcc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fcc_pkg::CFG_INDEX_W-1:0]  index;
  logic [fcc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/fcc_datapath.sv @@
module fcc_datapath #(
  parameter int CURVE_POINTS = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fcc_pkg::fcc_cmd_t                  ctl,
  output fcc_pkg::fcc_status_t               status,
  input  logic [1:0]                         item_cmd,
  input  logic signed [fcc_pkg::TEMP_W-1:0]  item_temperature,
  input  logic [fcc_pkg::RPM_W-1:0]          item_rpm,
  input  logic                               cfg_we,
  input  logic [fcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fcc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [fcc_pkg::PCT_W-1:0]          duty,
  output logic                               duty_written,
  output logic [1:0]                         fan_state
);

  // captured item
  logic [1:0]                         cmd_q;
  logic signed [fcc_pkg::TEMP_W-1:0]  temp_q;
  logic [fcc_pkg::RPM_W-1:0]          rpm_q;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_q  <= item_cmd;
      temp_q <= item_temperature;
      rpm_q  <= item_rpm;
    end
  end

  // configuration
  logic [fcc_pkg::POINT_W-1:0] pt [CURVE_POINTS];
  logic [fcc_pkg::RPM_W-1:0]   stall_rpm;
  logic [fcc_pkg::TIMER_W-1:0] start_ms;
  logic [fcc_pkg::TIMER_W-1:0] stall_wait_ms;

  for (genvar gi = 0; gi < CURVE_POINTS; gi++) begin : g_point
    if (gi < fcc_pkg::CURVE_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          pt[gi] <= fcc_pkg::point_default(gi);
        end else if (cfg_we && cfg_index == fcc_pkg::CFG_INDEX_W'(gi)) begin
          pt[gi] <= cfg_data[fcc_pkg::POINT_W-1:0];
        end
      end
    end else begin : g_fixed
      assign pt[gi] = fcc_pkg::point_default(gi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_rpm     <= fcc_pkg::STALL_RPM_RST;
      start_ms      <= fcc_pkg::START_MS_RST;
      stall_wait_ms <= fcc_pkg::STALL_WAIT_MS_RST;
    end else if (cfg_we) begin
      if (cfg_index == fcc_pkg::REG_STALL_RPM)     stall_rpm     <= cfg_data;
      if (cfg_index == fcc_pkg::REG_START_MS)      start_ms      <= cfg_data;
      if (cfg_index == fcc_pkg::REG_STALL_WAIT_MS) stall_wait_ms <= cfg_data;
    end
  end

  // segment search
  logic signed [12:0]          t_ext;
  logic signed [12:0]          deg_s [CURVE_POINTS];
  logic signed [12:0]          sel_a;
  logic signed [12:0]          sel_b;
  logic [fcc_pkg::PCT_W-1:0]   sel_pa;
  logic [fcc_pkg::PCT_W-1:0]   sel_pb;
  logic                        found;
  logic                        hit;
  logic [fcc_pkg::PCT_W-1:0]   clamp_val;
  logic signed [12:0]          diff_hi;
  logic signed [12:0]          diff_lo;
  logic signed [12:0]          diff_den;

  assign t_ext = {temp_q[fcc_pkg::TEMP_W-1], temp_q};

  for (genvar gi = 0; gi < CURVE_POINTS; gi++) begin : g_deg
    assign deg_s[gi] = $signed({2'b00, fcc_pkg::pt_deg16(pt[gi])});
  end

  always_comb begin
    found  = 1'b0;
    sel_a  = '0;
    sel_b  = '0;
    sel_pa = '0;
    sel_pb = '0;
    // descending, so the lowest matching segment wins
    for (int i = CURVE_POINTS - 2; i >= 0; i--) begin
      if (t_ext > deg_s[i] && t_ext <= deg_s[i+1]) begin
        found  = 1'b1;
        sel_a  = deg_s[i];
        sel_b  = deg_s[i+1];
        sel_pa = fcc_pkg::pt_pct(pt[i]);
        sel_pb = fcc_pkg::pt_pct(pt[i+1]);
      end
    end
    hit       = 1'b0;
    clamp_val = fcc_pkg::FULL_DUTY;
    if (t_ext <= deg_s[0]) begin
      clamp_val = fcc_pkg::pt_pct(pt[0]);
    end else if (t_ext > deg_s[CURVE_POINTS-1]) begin
      clamp_val = fcc_pkg::FULL_DUTY;
    end else if (found) begin
      hit = 1'b1;
    end
  end

  assign diff_hi  = sel_b - t_ext;
  assign diff_lo  = t_ext - sel_a;
  assign diff_den = sel_b - sel_a;

  // interpolation: (pa*(b-t) + pb*(t-a)) / (b-a), one quotient bit a cycle
  logic                          seg_hit_q;
  logic [fcc_pkg::DEG16_W-1:0]   dt_hi_q;
  logic [fcc_pkg::DEG16_W-1:0]   dt_lo_q;
  logic [fcc_pkg::DEG16_W-1:0]   den_q;
  logic [fcc_pkg::PCT_W-1:0]     pa_q;
  logic [fcc_pkg::PCT_W-1:0]     pb_q;
  logic [fcc_pkg::ACC_W-1:0]     acc;
  logic [fcc_pkg::PCT_W-1:0]     interp_q;
  logic [fcc_pkg::QIDX_W-1:0]    div_k;
  logic [fcc_pkg::ACC_W-1:0]     trial;

  assign trial = {{(fcc_pkg::ACC_W-fcc_pkg::DEG16_W){1'b0}}, den_q} << div_k;

  always_ff @(posedge clk) begin
    if (ctl.seg_find) begin
      seg_hit_q <= hit;
      dt_hi_q   <= diff_hi[fcc_pkg::DEG16_W-1:0];
      dt_lo_q   <= diff_lo[fcc_pkg::DEG16_W-1:0];
      den_q     <= diff_den[fcc_pkg::DEG16_W-1:0];
      pa_q      <= sel_pa;
      pb_q      <= sel_pb;
      interp_q  <= hit ? '0 : clamp_val;
      div_k     <= fcc_pkg::QIDX_W'(fcc_pkg::QBITS - 1);
    end
    if (ctl.mul_hi) begin
      acc <= fcc_pkg::ACC_W'(pa_q) * fcc_pkg::ACC_W'(dt_hi_q);
    end
    if (ctl.mul_lo) begin
      acc <= acc + fcc_pkg::ACC_W'(pb_q) * fcc_pkg::ACC_W'(dt_lo_q);
    end
    if (ctl.div_step) begin
      if (acc >= trial) begin
        acc             <= acc - trial;
        interp_q[div_k] <= 1'b1;
      end
      div_k <= div_k - 1'b1;
    end
  end

  assign status.is_temp  = (cmd_q == fcc_pkg::CMD_TEMP);
  assign status.seg_hit  = seg_hit_q;
  assign status.div_last = (div_k == '0);

  // fan state machine, one update per item
  logic [1:0]                  cur_state;
  logic [1:0]                  prev_state;
  logic [fcc_pkg::PCT_W-1:0]   target_speed;
  logic [fcc_pkg::PCT_W-1:0]   applied_duty;
  logic [fcc_pkg::TIMER_W-1:0] timer_left;

  logic [1:0]                  cur_state_next;
  logic [fcc_pkg::PCT_W-1:0]   target_next;
  logic [fcc_pkg::PCT_W-1:0]   duty_next;
  logic [fcc_pkg::TIMER_W-1:0] timer_next;
  logic                        written_next;
  logic                        entry;

  assign entry = (cur_state != prev_state);

  always_comb begin
    cur_state_next = cur_state;
    target_next    = target_speed;
    duty_next      = applied_duty;
    timer_next     = timer_left;
    written_next   = 1'b0;

    case (cmd_q)
      fcc_pkg::CMD_TEMP: target_next = interp_q;
      fcc_pkg::CMD_RPM: begin
        if (cur_state == fcc_pkg::ST_ON && rpm_q < stall_rpm) begin
          cur_state_next = fcc_pkg::ST_STALL;
        end
      end
      fcc_pkg::CMD_TIMEOUT: target_next = fcc_pkg::FULL_DUTY;
      default: begin
        if (timer_next != '0) timer_next = timer_next - 1'b1;
      end
    endcase

    case (cur_state)
      fcc_pkg::ST_OFF: begin
        if (entry) begin
          target_next  = '0;
          duty_next    = '0;
          written_next = 1'b1;
        end
        if (cur_state_next == cur_state && target_next > fcc_pkg::MIN_SETPOINT) begin
          cur_state_next = fcc_pkg::ST_START;
        end
      end
      fcc_pkg::ST_STALL: begin
        if (entry) begin
          target_next  = '0;
          duty_next    = '0;
          written_next = 1'b1;
          timer_next   = stall_wait_ms;
        end
        if (cur_state_next == cur_state && timer_next == '0) begin
          cur_state_next = fcc_pkg::ST_START;
        end
      end
      fcc_pkg::ST_START: begin
        if (entry) begin
          target_next  = fcc_pkg::FULL_DUTY;
          duty_next    = fcc_pkg::FULL_DUTY;
          written_next = 1'b1;
          timer_next   = start_ms;
        end
        if (cur_state_next == cur_state && timer_next == '0) begin
          cur_state_next = fcc_pkg::ST_ON;
        end
      end
      default: begin
        if (cur_state_next == cur_state) begin
          duty_next    = (target_next > fcc_pkg::FULL_DUTY) ? fcc_pkg::FULL_DUTY : target_next;
          written_next = 1'b1;
          if (target_next < fcc_pkg::MIN_SETPOINT) cur_state_next = fcc_pkg::ST_OFF;
        end
        if (cur_state_next != cur_state) target_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state    <= fcc_pkg::ST_OFF;
      prev_state   <= fcc_pkg::ST_OFF;
      target_speed <= '0;
      applied_duty <= '0;
      timer_left   <= '0;
    end else if (ctl.fan_step) begin
      cur_state    <= cur_state_next;
      prev_state   <= cur_state;
      target_speed <= target_next;
      applied_duty <= duty_next;
      timer_left   <= timer_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.fan_step) begin
      duty         <= duty_next;
      duty_written <= written_next;
      fan_state    <= cur_state_next;
    end
  end

endmodule

@@ rtl/fcc_ctrl.sv @@
module fcc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  fcc_pkg::fcc_status_t  status,
  output fcc_pkg::fcc_cmd_t     ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEG    = 3'd1;
  localparam logic [2:0] S_MULHI  = 3'd2;
  localparam logic [2:0] S_MULLO  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_STEP   = 3'd5;

  logic [2:0] state;
  logic [2:0] ctrl_state_next;
  logic       result_valid_next;

  always_comb begin
    ctl             = '0;
    item_ready      = 1'b0;
    ctrl_state_next = state;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          ctl.load_item   = 1'b1;
          ctrl_state_next = S_SEG;
        end
      end
      S_SEG: begin
        ctl.seg_find    = 1'b1;
        ctrl_state_next = status.is_temp ? S_MULHI : S_STEP;
      end
      S_MULHI: begin
        if (status.seg_hit) begin
          ctl.mul_hi      = 1'b1;
          ctrl_state_next = S_MULLO;
        end else begin
          ctrl_state_next = S_STEP;
        end
      end
      S_MULLO: begin
        ctl.mul_lo      = 1'b1;
        ctrl_state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (status.div_last) ctrl_state_next = S_STEP;
      end
      S_STEP: begin
        // wait for the result register to drain
        if (!result_valid || result_ready) begin
          ctl.fan_step    = 1'b1;
          ctrl_state_next = S_IDLE;
        end
      end
      default: ctrl_state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (ctl.fan_step) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= ctrl_state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

@@ rtl/fan_curve_controller_core.sv @@
// Channel  | Dir | Beat contents
// items    | in  | cmd, temperature, rpm
// results  | out | duty, duty_written, fan_state (one per item)
// cfg      | in  | index, data (register write, always ready)
//
// Rpm, timeout and tick items go from acceptance through segment search to
// the fan step. A temperature inside the curve takes segment search, a high
// and a low multiply, then the divider producing one quotient bit a cycle (7 bits).
// Temperatures outside the curve skip the multiply and divide.
// One item is in work at a time; the next is taken while a result waits.
// Synchronous active-high reset restores the curve and timing registers.
module fan_curve_controller_core #(
  parameter int CURVE_POINTS = 5
) (
  input  logic          clk,
  input  logic          rst,
  fcc_item_if.sink      items,
  fcc_result_if.source  results,
  fcc_cfg_if.sink       cfg
);

  fcc_pkg::fcc_cmd_t    ctl;
  fcc_pkg::fcc_status_t status;

  assign cfg.ready = 1'b1;

  fcc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (items.valid),
    .item_ready   (items.ready),
    .result_valid (results.valid),
    .result_ready (results.ready),
    .status       (status),
    .ctl          (ctl)
  );

  fcc_datapath #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .status           (status),
    .item_cmd         (items.cmd),
    .item_temperature (items.temperature),
    .item_rpm         (items.rpm),
    .cfg_we           (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .duty             (results.duty),
    .duty_written     (results.duty_written),
    .fan_state        (results.fan_state)
  );

endmodule

@@ rtl/fcc_checker.sv @@
module fcc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [fcc_pkg::PCT_W-1:0]  duty,
  input logic                       duty_written,
  input logic [1:0]                 fan_state
);

  logic       item_beat;
  logic       result_beat;
  logic [1:0] pending;

  assign item_beat   = item_valid && item_ready;
  assign result_beat = result_valid && result_ready;

  // items taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(item_beat) - 2'(result_beat);
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable({duty, duty_written, fan_state}))
    else $error("result beat changed while stalled");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> duty <= fcc_pkg::FULL_DUTY)
    else $error("duty above full drive");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 2'd0)
    else $error("result without an item");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    item_beat |-> pending != 2'd2)
    else $error("item taken with two already outstanding");

endmodule

bind fan_curve_controller_core fcc_checker u_fcc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (items.valid),
  .item_ready   (items.ready),
  .result_valid (results.valid),
  .result_ready (results.ready),
  .duty         (results.duty),
  .duty_written (results.duty_written),
  .fan_state    (results.fan_state)
);

@@ tb/testbench.sv @@
module testbench;

  localparam int ITEMS_PER_PHASE = 115;
  localparam int PHASES          = 8;
  localparam int STALL_LIMIT     = 3000;
  localparam int TAIL_CYCLES     = 40;
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_AFTER      = 300;
  localparam int MAX_REPORTS     = 100;
  localparam int PCT_MAX         = 100;
  localparam int POINT_MAX       = 25700;
  localparam int DEG_MAX         = 100;

  localparam logic [fcc_pkg::CFG_INDEX_W-1:0] REG_BEYOND_LIST = 8'd8;
  localparam logic [fcc_pkg::CFG_INDEX_W-1:0] REG_TOP_INDEX   = 8'hFF;

  // curve shapes used by the phases
  localparam int CURVE_SORTED    = 0;
  localparam int CURVE_SCRAMBLED = 1;
  localparam int CURVE_FLOOR     = 2;
  localparam int CURVE_CEILING   = 3;
  localparam int CURVE_LOW_START = 4;

  // receiver ready patterns
  localparam int RX_OPEN   = 0;
  localparam int RX_HALF   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_BLINK  = 3;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic [fcc_pkg::TEMP_W-1:0] temperature;
    logic [fcc_pkg::RPM_W-1:0]  rpm;
  } fan_item_t;

  typedef struct packed {
    logic [fcc_pkg::PCT_W-1:0] duty;
    logic                      duty_written;
    logic [1:0]                fan_state;
  } fan_result_t;

  logic clk = 1'b0;
  logic rst;

  fcc_item_if   items_ch ();
  fcc_result_if results_ch ();
  fcc_cfg_if    cfg_ch ();

  fan_curve_controller_core DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  always #5 clk = ~clk;

  // predictor copy of the block
  logic [fcc_pkg::POINT_W-1:0] curve_m [fcc_pkg::CURVE_REGS];
  logic [fcc_pkg::RPM_W-1:0]   stall_rpm_m;
  logic [fcc_pkg::TIMER_W-1:0] start_ms_m;
  logic [fcc_pkg::TIMER_W-1:0] stall_wait_m;
  logic [1:0]                  state_m;
  logic [1:0]                  prev_state_m;
  int                          target_m;
  int                          duty_m;
  logic [fcc_pkg::TIMER_W-1:0] timer_m;

  // settings planned for the current phase
  logic [fcc_pkg::POINT_W-1:0] curve_plan [fcc_pkg::CURVE_REGS];
  int                          stall_plan;

  fan_item_t   queued_samples [$];
  fan_result_t pending_fan_results [$];
  int          items_left;
  int          results_seen;
  int          mismatch_count;
  int          quiet_cycles;
  logic        item_beat;

  int          burst_left;
  int          gap_left;
  fan_item_t   next_item;

  int          hold_left;
  logic        hold_done;
  int          rx_mode;
  int          rx_mode_left;
  int          rx_cycle;

  function automatic int curve_deg16(input logic [fcc_pkg::POINT_W-1:0] p);
    int d;
    d = int'(p[14:8]);
    if (d > DEG_MAX) d = DEG_MAX;
    return d * 16;
  endfunction

  function automatic int curve_pct(input logic [fcc_pkg::POINT_W-1:0] p);
    int v;
    v = int'(p[7:0]);
    if (v > PCT_MAX) v = PCT_MAX;
    return v;
  endfunction

  function automatic int curve_speed(input int t);
    int lo_deg, hi_deg, lo_pct, hi_pct, span;
    if (t <= curve_deg16(curve_m[0])) return curve_pct(curve_m[0]);
    if (t > curve_deg16(curve_m[fcc_pkg::CURVE_REGS-1])) return PCT_MAX;
    for (int i = 0; i < fcc_pkg::CURVE_REGS - 1; i++) begin
      lo_deg = curve_deg16(curve_m[i]);
      hi_deg = curve_deg16(curve_m[i+1]);
      if (t > lo_deg && t <= hi_deg) begin
        lo_pct = curve_pct(curve_m[i]);
        hi_pct = curve_pct(curve_m[i+1]);
        span   = hi_deg - lo_deg;
        return (lo_pct * span + (t - lo_deg) * (hi_pct - lo_pct)) / span;
      end
    end
    // no segment matched: curve out of order
    return PCT_MAX;
  endfunction

  function automatic void clear_fan_model();
    curve_m[0]   = 15'd20;
    curve_m[1]   = 15'd5140;
    curve_m[2]   = 15'd9005;
    curve_m[3]   = 15'd11610;
    curve_m[4]   = 15'd15460;
    stall_rpm_m  = fcc_pkg::STALL_RPM_RST;
    start_ms_m   = fcc_pkg::START_MS_RST;
    stall_wait_m = fcc_pkg::STALL_WAIT_MS_RST;
    state_m      = fcc_pkg::ST_OFF;
    prev_state_m = fcc_pkg::ST_OFF;
    target_m     = 0;
    duty_m       = 0;
    timer_m      = '0;
  endfunction

  function automatic void load_register(input logic [fcc_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [fcc_pkg::CFG_DATA_W-1:0] val);
    if (idx < fcc_pkg::CFG_INDEX_W'(fcc_pkg::CURVE_REGS))
      curve_m[idx[2:0]] = val[fcc_pkg::POINT_W-1:0];
    else if (idx == fcc_pkg::REG_STALL_RPM) stall_rpm_m = val;
    else if (idx == fcc_pkg::REG_START_MS) start_ms_m = val;
    else if (idx == fcc_pkg::REG_STALL_WAIT_MS) stall_wait_m = val;
  endfunction

  function automatic fan_result_t advance_fan_model(input fan_item_t it);
    fan_result_t r;
    logic [1:0]  nxt;
    logic        wrote;
    logic        arriving;
    nxt      = state_m;
    wrote    = 1'b0;
    arriving = (state_m != prev_state_m);
    case (it.cmd)
      fcc_pkg::CMD_TEMP:
        target_m = curve_speed(int'($signed(it.temperature)));
      fcc_pkg::CMD_RPM:
        if (state_m == fcc_pkg::ST_ON && it.rpm < stall_rpm_m) nxt = fcc_pkg::ST_STALL;
      fcc_pkg::CMD_TIMEOUT:
        target_m = PCT_MAX;
      default:
        if (timer_m != '0) timer_m = timer_m - 1'b1;
    endcase
    prev_state_m = state_m;
    case (state_m)
      fcc_pkg::ST_OFF: begin
        if (arriving) begin
          target_m = 0;
          duty_m   = 0;
          wrote    = 1'b1;
        end
        if (nxt == state_m && target_m > int'(fcc_pkg::MIN_SETPOINT)) nxt = fcc_pkg::ST_START;
      end
      fcc_pkg::ST_STALL: begin
        if (arriving) begin
          target_m = 0;
          duty_m   = 0;
          wrote    = 1'b1;
          timer_m  = stall_wait_m;
        end
        if (nxt == state_m && timer_m == '0) nxt = fcc_pkg::ST_START;
      end
      fcc_pkg::ST_START: begin
        if (arriving) begin
          target_m = PCT_MAX;
          duty_m   = PCT_MAX;
          wrote    = 1'b1;
          timer_m  = start_ms_m;
        end
        if (nxt == state_m && timer_m == '0) nxt = fcc_pkg::ST_ON;
      end
      default: begin
        // a pending stall skips the drive update
        if (nxt == state_m) begin
          duty_m = (target_m > PCT_MAX) ? PCT_MAX : target_m;
          wrote  = 1'b1;
          if (target_m < int'(fcc_pkg::MIN_SETPOINT)) nxt = fcc_pkg::ST_OFF;
        end
        if (nxt != state_m) target_m = 0;
      end
    endcase
    state_m        = nxt;
    r.duty         = fcc_pkg::PCT_W'(duty_m);
    r.duty_written = wrote;
    r.fan_state    = state_m;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic queue_item(input logic [1:0] cmd, input int temp, input int speed);
    fan_item_t it;
    it.cmd         = cmd;
    it.temperature = fcc_pkg::TEMP_W'(temp);
    it.rpm         = fcc_pkg::RPM_W'(speed);
    queued_samples.push_back(it);
    items_left++;
  endtask

  function automatic int pick_temperature();
    int r, k, lo, hi;
    r  = int'($urandom_range(0, 9));
    k  = int'($urandom_range(0, fcc_pkg::CURVE_REGS - 1));
    lo = curve_deg16(curve_plan[0]) - 40;
    hi = curve_deg16(curve_plan[fcc_pkg::CURVE_REGS-1]) + 40;
    if (hi <= lo) hi = lo + 400;
    if (r < 2) return int'($signed(fcc_pkg::TEMP_W'($urandom)));
    // on a point or one sixteenth either side
    if (r < 4) return curve_deg16(curve_plan[k]) + int'($urandom_range(0, 2)) - 1;
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic int pick_rpm();
    int r, v;
    r = int'($urandom_range(0, 9));
    if (r < 3) return int'($urandom_range(0, 65535));
    if (r < 6 && stall_plan != 0) return int'($urandom_range(stall_plan - 1, 0));
    v = stall_plan + int'($urandom_range(0, 300));
    return (v > 65535) ? 65535 : v;
  endfunction

  task automatic queue_random_item();
    int r;
    fan_item_t it;
    r              = int'($urandom_range(0, 99));
    it.temperature = fcc_pkg::TEMP_W'($urandom);
    it.rpm         = fcc_pkg::RPM_W'($urandom);
    if (r < 35) begin
      it.cmd         = fcc_pkg::CMD_TEMP;
      it.temperature = fcc_pkg::TEMP_W'(pick_temperature());
    end else if (r < 55) begin
      it.cmd = fcc_pkg::CMD_RPM;
      it.rpm = fcc_pkg::RPM_W'(pick_rpm());
    end else if (r < 62) begin
      it.cmd = fcc_pkg::CMD_TIMEOUT;
    end else begin
      it.cmd = fcc_pkg::CMD_TICK;
    end
    queued_samples.push_back(it);
    items_left++;
  endtask

  task automatic plan_curve(input int kind);
    int degs [fcc_pkg::CURVE_REGS];
    int pct, v, tmp;
    for (int i = 0; i < fcc_pkg::CURVE_REGS; i++) degs[i] = int'($urandom_range(0, DEG_MAX));
    if (kind == CURVE_SORTED || kind == CURVE_LOW_START) begin
      for (int i = 0; i < fcc_pkg::CURVE_REGS - 1; i++)
        for (int j = 0; j < fcc_pkg::CURVE_REGS - 1 - i; j++)
          if (degs[j] > degs[j+1]) begin
            tmp       = degs[j];
            degs[j]   = degs[j+1];
            degs[j+1] = tmp;
          end
    end
    for (int i = 0; i < fcc_pkg::CURVE_REGS; i++) begin
      pct = (kind == CURVE_LOW_START) ? int'($urandom_range(0, 255))
                                      : int'($urandom_range(0, PCT_MAX));
      if (i == 0 && kind == CURVE_SORTED) pct = int'($urandom_range(0, 10));
      if (i == 0 && kind == CURVE_LOW_START) pct = 0;
      v = degs[i] * 256 + pct;
      if (v > POINT_MAX) v = POINT_MAX;
      if (kind == CURVE_FLOOR) v = 0;
      if (kind == CURVE_CEILING) v = POINT_MAX;
      if (kind == CURVE_LOW_START && i == fcc_pkg::CURVE_REGS - 1) v = POINT_MAX;
      curve_plan[i] = fcc_pkg::POINT_W'(v);
    end
  endtask

  task automatic write_reg(input logic [fcc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [fcc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (items_left != 0 || pending_fan_results.size() != 0);
  endtask

  // beats are taken and checked here; predictor runs on every accepted item
  always @(posedge clk) begin
    fan_item_t   taken;
    fan_result_t got;
    fan_result_t want;
    logic        any_beat;
    item_beat = 1'b0;
    any_beat  = 1'b0;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        load_register(cfg_ch.index, cfg_ch.data);
        any_beat = 1'b1;
      end
      if (items_ch.valid && items_ch.ready) begin
        taken.cmd         = items_ch.cmd;
        taken.temperature = items_ch.temperature;
        taken.rpm         = items_ch.rpm;
        pending_fan_results.push_back(advance_fan_model(taken));
        items_left--;
        item_beat = 1'b1;
        any_beat  = 1'b1;
      end
      if (results_ch.valid && results_ch.ready) begin
        any_beat = 1'b1;
        results_seen++;
        got.duty         = results_ch.duty;
        got.duty_written = results_ch.duty_written;
        got.fan_state    = results_ch.fan_state;
        if (pending_fan_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding, duty", int'(got.duty), -1);
        end else begin
          want = pending_fan_results.pop_front();
          if (got.duty !== want.duty)
            report_mismatch("duty", int'(got.duty), int'(want.duty));
          if (got.duty_written !== want.duty_written)
            report_mismatch("duty_written", int'(got.duty_written), int'(want.duty_written));
          if (got.fan_state !== want.fan_state)
            report_mismatch("fan_state", int'(got.fan_state), int'(want.fan_state));
        end
      end
      quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
    end
  end

  // item driver: bursts of random length, random gaps between them
  always @(negedge clk) begin
    if (rst) begin
      items_ch.valid <= 1'b0;
    end else if (!items_ch.valid || item_beat) begin
      if (gap_left > 0) begin
        gap_left--;
        items_ch.valid <= 1'b0;
      end else if (queued_samples.size() > 0) begin
        next_item = queued_samples.pop_front();
        items_ch.cmd         <= next_item.cmd;
        items_ch.temperature <= next_item.temperature;
        items_ch.rpm         <= next_item.rpm;
        items_ch.valid       <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = int'($urandom_range(1, 24));
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : int'($urandom_range(1, 12));
        end
      end else begin
        items_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: its own ready pattern, plus one long hold-off
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      results_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      results_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_left > 0) begin
        rx_mode_left--;
      end else begin
        rx_mode      = int'($urandom_range(RX_OPEN, RX_BLINK));
        rx_mode_left = int'($urandom_range(20, 80));
      end
      case (rx_mode)
        RX_OPEN:   results_ch.ready <= 1'b1;
        RX_HALF:   results_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: results_ch.ready <= ($urandom_range(0, 5) == 0);
        default:   results_ch.ready <= (rx_cycle % 4 != 0);
      endcase
    end
  end

  initial begin
    do @(negedge clk); while (quiet_cycles < STALL_LIMIT);
    $display("[%0t] no beat for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int start_plan;
    int wait_plan;
    int kind;
    rst                  = 1'b1;
    items_ch.valid       = 1'b0;
    items_ch.cmd         = fcc_pkg::CMD_TEMP;
    items_ch.temperature = '0;
    items_ch.rpm         = '0;
    results_ch.ready     = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    items_left           = 0;
    results_seen         = 0;
    mismatch_count       = 0;
    quiet_cycles         = 0;
    item_beat            = 1'b0;
    burst_left           = 0;
    gap_left             = 0;
    hold_left            = 0;
    hold_done            = 1'b0;
    rx_mode              = RX_OPEN;
    rx_mode_left         = 0;
    rx_cycle             = 0;
    stall_plan           = int'(fcc_pkg::STALL_RPM_RST);
    clear_fan_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings; nothing here leaves the off state
    queue_item(fcc_pkg::CMD_TICK, 0, 0);
    queue_item(fcc_pkg::CMD_TICK, -1, 65535);
    queue_item(fcc_pkg::CMD_RPM, 0, 0);
    queue_item(fcc_pkg::CMD_RPM, 0, 65535);
    queue_item(fcc_pkg::CMD_RPM, 0, 139);
    queue_item(fcc_pkg::CMD_RPM, 0, 140);
    wait_drained();

    // zero start and stall times: the start and stall states are left on their entry beat
    write_reg(fcc_pkg::REG_STALL_RPM, 16'd1000);
    write_reg(fcc_pkg::REG_START_MS, 16'd0);
    write_reg(fcc_pkg::REG_STALL_WAIT_MS, 16'd0);
    stall_plan = 1000;
    queue_item(fcc_pkg::CMD_TEMP, -2048, 0);
    queue_item(fcc_pkg::CMD_TICK, 0, 0);
    queue_item(fcc_pkg::CMD_RPM, 0, 999);
    queue_item(fcc_pkg::CMD_TICK, 0, 0);
    queue_item(fcc_pkg::CMD_RPM, 0, 65535);
    queue_item(fcc_pkg::CMD_TEMP, 0, 0);      // exactly on the first point
    queue_item(fcc_pkg::CMD_TEMP, 1, 0);
    queue_item(fcc_pkg::CMD_TEMP, 321, 0);
    queue_item(fcc_pkg::CMD_TEMP, 560, 0);
    queue_item(fcc_pkg::CMD_TEMP, 961, 0);    // just past the last point
    queue_item(fcc_pkg::CMD_TEMP, 960, 0);
    queue_item(fcc_pkg::CMD_TEMP, -1, 0);
    queue_item(fcc_pkg::CMD_TIMEOUT, 0, 0);
    queue_item(fcc_pkg::CMD_RPM, 0, 1000);
    queue_item(fcc_pkg::CMD_TEMP, 2047, 0);
    queue_item(fcc_pkg::CMD_RPM, 0, 0);
    queue_item(fcc_pkg::CMD_TICK, 0, 0);
    queue_item(fcc_pkg::CMD_TEMP, 700, 0);
    queue_item(fcc_pkg::CMD_TICK, 0, 0);      // timer already at zero
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      kind       = CURVE_SORTED;
      stall_plan = int'($urandom_range(1, 5000));
      start_plan = int'($urandom_range(0, 6));
      wait_plan  = int'($urandom_range(0, 6));
      case (ph)
        0: begin
          kind       = CURVE_LOW_START;
          stall_plan = 0;
          start_plan = 1;
          wait_plan  = 1;
        end
        2: kind = CURVE_SCRAMBLED;
        3: kind = CURVE_FLOOR;
        5: kind = CURVE_LOW_START;
        6: wait_plan = 65535;
        7: begin
          // long timers last: once loaded they hold the state for good
          kind       = CURVE_CEILING;
          stall_plan = 65535;
          start_plan = 65535;
          wait_plan  = 65535;
        end
        default: kind = CURVE_SORTED;
      endcase
      plan_curve(kind);
      for (int i = 0; i < fcc_pkg::CURVE_REGS; i++)
        write_reg(fcc_pkg::CFG_INDEX_W'(i), {1'b0, curve_plan[i]});
      write_reg(fcc_pkg::REG_STALL_RPM, fcc_pkg::CFG_DATA_W'(stall_plan));
      write_reg(fcc_pkg::REG_START_MS, fcc_pkg::CFG_DATA_W'(start_plan));
      write_reg(fcc_pkg::REG_STALL_WAIT_MS, fcc_pkg::CFG_DATA_W'(wait_plan));
      if (ph == 0) write_reg(REG_BEYOND_LIST, fcc_pkg::CFG_DATA_W'($urandom));
      if (ph == 4) write_reg(REG_TOP_INDEX, fcc_pkg::CFG_DATA_W'($urandom));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_random_item();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_fan_results.size() != 0)
      report_mismatch("results still outstanding", 0, pending_fan_results.size());
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
